// ===== rtl/mutex_table_engine_core_defines.svh =====
// ----------------------------------------------------------------------------
// Mutex table engine assertion macros
// Shared concurrent assertion forms for the checker of the mutex table engine.
// ----------------------------------------------------------------------------
`ifndef MUTEX_TABLE_ENGINE_CORE_DEFINES_SVH
`define MUTEX_TABLE_ENGINE_CORE_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent
`define MTE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its antecedent
`define MTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mte_pkg.sv =====
// ----------------------------------------------------------------------------
// Mutex table engine package
// Field widths, request/state/status codes and the token that walks the cells.
// ----------------------------------------------------------------------------
package mte_pkg;

    localparam int MUTEX_SLOTS_DEF = 64;
    localparam int ID_W            = 16;
    localparam int WAKE_W          = 6;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_DEALLOC = 2'd1,
        REQ_LOCK    = 2'd2,
        REQ_UNLOCK  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        SLOT_FREE     = 2'd0,
        SLOT_UNLOCKED = 2'd1,
        SLOT_LOCKED   = 2'd2
    } slot_state_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_FAIL = 2'd1,
        STAT_BUSY = 2'd2
    } status_t;

    // Request in flight plus its result so far
    typedef struct packed {
        logic              valid;
        req_type_t         req;
        logic [ID_W-1:0]   lock_id;
        logic [ID_W-1:0]   requester_id;
        logic [ID_W-1:0]   new_id;
        logic              done;
        status_t           status;
        logic [ID_W-1:0]   result_id;
        logic              wake_valid;
        logic [WAKE_W-1:0] wake_slot;
    } mte_tok_t;

endpackage

// ===== rtl/mte_if.sv =====
// ----------------------------------------------------------------------------
// Mutex table engine channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mte_req_if
    import mte_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [ID_W-1:0]   lock_id;
    logic [ID_W-1:0]   requester_id;

    modport source (output valid, req_type, lock_id, requester_id, input ready);
    modport sink   (input valid, req_type, lock_id, requester_id, output ready);
endinterface

interface mte_rsp_if
    import mte_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [ID_W-1:0]   result_id;
    logic              wake_valid;
    logic [WAKE_W-1:0] wake_slot;

    modport source (output valid, status, result_id, wake_valid, wake_slot, input ready);
    modport sink   (input valid, status, result_id, wake_valid, wake_slot, output ready);
endinterface

// ===== rtl/mte_cell.sv =====
// ----------------------------------------------------------------------------
// Mutex table engine cell
// Holds one mutex slot and acts on the request token passing through it.
// ----------------------------------------------------------------------------
module mte_cell
    import mte_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic     clk,
    input  logic     rst_n,
    input  mte_tok_t tok_in,
    output mte_tok_t tok_out
);

    localparam logic [WAKE_W-1:0] SlotTag = WAKE_W'(IDX);

    slot_state_t     state_reg, state_next;
    logic [ID_W-1:0] id_reg, id_next;
    logic [ID_W-1:0] owner_reg, owner_next;
    mte_tok_t        tok_reg, tok_next;
    logic            match;

    assign match = (state_reg != SLOT_FREE) && (id_reg == tok_in.lock_id);

    // Serve the request if no earlier cell has claimed it
    always_comb
    begin
        tok_next   = tok_in;
        state_next = state_reg;
        id_next    = id_reg;
        owner_next = owner_reg;
        if (tok_in.valid && !tok_in.done)
        begin
            unique case (tok_in.req)
                REQ_ALLOC:
                begin
                    if (state_reg == SLOT_FREE)
                    begin
                        state_next         = SLOT_UNLOCKED;
                        id_next            = tok_in.new_id;
                        owner_next         = '0;
                        tok_next.done      = 1'b1;
                        tok_next.status    = STAT_OK;
                        tok_next.result_id = tok_in.new_id;
                    end
                end
                REQ_DEALLOC:
                begin
                    if (match)
                    begin
                        tok_next.done = 1'b1;
                        if (state_reg != SLOT_LOCKED)
                        begin
                            state_next      = SLOT_FREE;
                            id_next         = '0;
                            owner_next      = '0;
                            tok_next.status = STAT_OK;
                        end
                    end
                end
                REQ_LOCK:
                begin
                    if (match)
                    begin
                        tok_next.done = 1'b1;
                        if (state_reg == SLOT_LOCKED)
                        begin
                            tok_next.status = STAT_BUSY;
                        end
                        else
                        begin
                            state_next      = SLOT_LOCKED;
                            owner_next      = tok_in.requester_id;
                            tok_next.status = STAT_OK;
                        end
                    end
                end
                REQ_UNLOCK:
                begin
                    if (match)
                    begin
                        tok_next.done = 1'b1;
                        if (state_reg == SLOT_LOCKED)
                        begin
                            state_next          = SLOT_UNLOCKED;
                            owner_next          = '0;
                            tok_next.status     = STAT_OK;
                            tok_next.wake_valid = 1'b1;
                            tok_next.wake_slot  = SlotTag;
                        end
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    // Hold the slot and advance the token one cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SLOT_FREE;
            id_reg    <= '0;
            owner_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            id_reg    <= id_next;
            owner_reg <= owner_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/mutex_table_engine_core.sv =====
// A result is registered in the response register once the request token leaves the last cell.
// The request token walks the row of slot cells, one cell per cycle.
// A new request is taken only in idle, after the previous token has left the row, while the response is free or taken.
// Reset (async, active low): all slots free, ids and owners zero, id counter one.
// ----------------------------------------------------------------------------
// Mutex table engine core
// Table of mutex slots as a chain of cells with alloc, dealloc, lock, unlock.
// ----------------------------------------------------------------------------
module mutex_table_engine_core
    import mte_pkg::*;
#(
    parameter int MUTEX_SLOTS = MUTEX_SLOTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    mte_req_if.sink   req,
    mte_rsp_if.source rsp
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } fsm_t;

    fsm_t              state_reg;
    logic [ID_W-1:0]   next_id_reg;
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [ID_W-1:0]   out_result_id_reg;
    logic              out_wake_valid_reg;
    logic [WAKE_W-1:0] out_wake_slot_reg;
    logic              in_acc;
    mte_tok_t          tok [MUTEX_SLOTS+1];
    mte_tok_t          last;

    // Accept only when idle and the output register is free by the next edge
    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign in_acc    = req.valid && req.ready;

    // Build the token entering the first cell
    always_comb
    begin
        tok[0].valid        = in_acc;
        tok[0].req          = req_type_t'(req.req_type);
        tok[0].lock_id      = req.lock_id;
        tok[0].requester_id = req.requester_id;
        tok[0].new_id       = next_id_reg;
        tok[0].done         = 1'b0;
        tok[0].status       = STAT_FAIL;
        tok[0].result_id    = '0;
        tok[0].wake_valid   = 1'b0;
        tok[0].wake_slot    = '0;
    end

    // Row of slot cells
    for (genvar i = 0; i < MUTEX_SLOTS; i++)
    begin : g_cell
        mte_cell #(
            .IDX(i)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .tok_in (tok[i]),
            .tok_out(tok[i+1])
        );
    end

    assign last = tok[MUTEX_SLOTS];

    // Sequence requests, advance the id counter, hold the response
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            next_id_reg        <= ID_W'(1);
            out_valid_reg      <= 1'b0;
            out_status_reg     <= STAT_FAIL;
            out_result_id_reg  <= '0;
            out_wake_valid_reg <= 1'b0;
            out_wake_slot_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (last.valid)
                    begin
                        state_reg          <= S_IDLE;
                        out_valid_reg      <= 1'b1;
                        out_status_reg     <= last.status;
                        out_result_id_reg  <= last.result_id;
                        out_wake_valid_reg <= last.wake_valid;
                        out_wake_slot_reg  <= last.wake_slot;
                        if (last.req == REQ_ALLOC && last.status == STAT_OK)
                        begin
                            next_id_reg <= (next_id_reg == {ID_W{1'b1}}) ?
                                           ID_W'(1) : next_id_reg + ID_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.result_id  = out_result_id_reg;
    assign rsp.wake_valid = out_wake_valid_reg;
    assign rsp.wake_slot  = out_wake_slot_reg;

endmodule

// ===== rtl/mte_checker.sv =====
// ----------------------------------------------------------------------------
// Mutex table engine checker
// Port-level assertions on the engine, attached to the core by bind.
// ----------------------------------------------------------------------------
`include "mutex_table_engine_core_defines.svh"

module mte_checker
    import mte_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [1:0]        rsp_status,
    input logic [ID_W-1:0]   rsp_result_id,
    input logic              rsp_wake_valid,
    input logic [WAKE_W-1:0] rsp_wake_slot
);

    // A stalled response holds its payload
    `MTE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_result_id) && $stable(rsp_wake_slot), "stalled response changed")

    // One request at a time: no accept right after an accept
    `MTE_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request accepted while busy")

    // Wake only on a successful unlock
    `MTE_ASSERT_SAME(a_wake_ok, rsp_valid && rsp_wake_valid, rsp_status == STAT_OK, "wake on failed request")

    // A granted id comes only with an ok status and no wake
    `MTE_ASSERT_SAME(a_id_ok, rsp_valid && rsp_result_id != '0, rsp_status == STAT_OK && !rsp_wake_valid, "id on failed request")

    // Slot index is zero unless a wake is reported
    `MTE_ASSERT_SAME(a_slot_zero, rsp_valid && !rsp_wake_valid, rsp_wake_slot == '0, "slot without wake")

endmodule

bind mutex_table_engine_core mte_checker u_mte_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_result_id (rsp.result_id),
    .rsp_wake_valid(rsp.wake_valid),
    .rsp_wake_slot (rsp.wake_slot)
);
